[sv/nsc_pkg.sv]
// nsc_pkg: shared types, constants and helper functions of the natural string compare
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

  // buffer geometry
  localparam int MAX_LEN   = 256;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int ART_BYTES = 4;
  localparam int ART_W     = 8 * ART_BYTES;

  // result width and saturation bound
  localparam int DIFF_W     = 10;
  localparam int DIFF_LIMIT = 256;
  localparam logic signed [DIFF_W-1:0] DIFF_ZERO    = DIFF_W'(0);
  localparam logic signed [DIFF_W-1:0] DIFF_ONE     = DIFF_W'(1);
  localparam logic signed [DIFF_W-1:0] DIFF_NEG_ONE = -DIFF_ONE;
  localparam logic signed [DIFF_W-1:0] DIFF_HI      = DIFF_W'(DIFF_LIMIT);
  localparam logic signed [DIFF_W-1:0] DIFF_LO      = -DIFF_HI;

  // command codes
  localparam logic [2:0] CMD_APPEND_A = 3'd0;
  localparam logic [2:0] CMD_APPEND_B = 3'd1;
  localparam logic [2:0] CMD_NULL_A   = 3'd2;
  localparam logic [2:0] CMD_NULL_B   = 3'd3;
  localparam logic [2:0] CMD_COMPARE  = 3'd4;

  // character codes
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_ZERO     = "0";
  localparam logic [7:0] CH_NINE     = "9";
  localparam logic [7:0] CH_UP_A     = "A";
  localparam logic [7:0] CH_UP_Z     = "Z";
  localparam logic [7:0] CH_SPACE    = " ";
  localparam logic [7:0] CH_LO_A     = "a";
  localparam logic [7:0] CH_LO_E     = "e";
  localparam logic [7:0] CH_LO_H     = "h";
  localparam logic [7:0] CH_LO_N     = "n";
  localparam logic [7:0] CH_LO_T     = "t";
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // channel payloads
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] difference;
    logic                     overflowed;
  } out_item_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ART_RD,
    ST_ART_EV,
    ST_ART_SET,
    ST_CH_RD,
    ST_CH_EV,
    ST_ZS_RD,
    ST_ZS_EV,
    ST_RN_RD,
    ST_RN_EV,
    ST_RN_CMP,
    ST_DG_RD,
    ST_DG_EV,
    ST_FINISH
  } state_t;

  // scan pointer operations
  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_ARTICLE,
    PTR_STEP
  } ptr_op_t;

  // digit run end pointer operations
  typedef enum logic [1:0] {
    RUN_HOLD,
    RUN_LOAD,
    RUN_STEP
  } run_op_t;

  // result register sources
  typedef enum logic [2:0] {
    RES_HOLD,
    RES_ABSENT,
    RES_END,
    RES_CHAR,
    RES_RUN
  } res_src_t;

  // controller to datapath commands
  typedef struct packed {
    logic     item_take;
    ptr_op_t  ptr_op;
    run_op_t  run_op;
    logic     step_a;
    logic     step_b;
    logic     sel_run;
    logic     art_shift;
    res_src_t res_src;
    logic     out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic absent_any;
    logic end_a;
    logic end_b;
    logic digit_a;
    logic digit_b;
    logic zero_a;
    logic zero_b;
    logic char_ne;
    logic art_last;
    logic run_ne;
    logic digits_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // leading article length; first byte sits in the top byte of the word
  function automatic logic [LEN_W-1:0] article_len(input logic [ART_W-1:0] w);
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [7:0]       b3;
    logic [LEN_W-1:0] n;
    b0 = to_lower(w[ART_W-1 -: 8]);
    b1 = to_lower(w[ART_W-9 -: 8]);
    b2 = to_lower(w[ART_W-17 -: 8]);
    b3 = to_lower(w[ART_W-25 -: 8]);
    n  = LEN_W'(0);
    if (b0 == CH_LO_T && b1 == CH_LO_H && b2 == CH_LO_E && b3 == CH_SPACE) begin
      n = LEN_W'(4);
    end else if (b0 == CH_LO_A && b1 == CH_LO_N && b2 == CH_SPACE) begin
      n = LEN_W'(3);
    end else if (b0 == CH_LO_A && b1 == CH_SPACE) begin
      n = LEN_W'(2);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[sv/nsc_ctrl.sv]
// nsc_ctrl: state machine that sequences loads and the compare walk
`timescale 1ns / 1ps
`default_nettype none

module nsc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [2:0]         command,
  output logic                    in_ready,
  input  wire nsc_pkg::dp_stat_t  stat,
  output nsc_pkg::ctrl_cmd_t      cmd
);
  import nsc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && command == CMD_COMPARE) begin
          state_nxt = stat.absent_any ? ST_FINISH : ST_ART_RD;
        end
      end
      ST_ART_RD:  state_nxt = ST_ART_EV;
      ST_ART_EV:  state_nxt = stat.art_last ? ST_ART_SET : ST_ART_RD;
      ST_ART_SET: state_nxt = ST_CH_RD;
      ST_CH_RD:   state_nxt = ST_CH_EV;
      ST_CH_EV: begin
        priority if (stat.end_a || stat.end_b) begin
          state_nxt = ST_FINISH;
        end else if (stat.digit_a && stat.digit_b) begin
          state_nxt = ST_ZS_RD;
        end else if (stat.char_ne) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_CH_RD;
        end
      end
      ST_ZS_RD:  state_nxt = ST_ZS_EV;
      ST_ZS_EV:  state_nxt = (stat.zero_a || stat.zero_b) ? ST_ZS_RD : ST_RN_RD;
      ST_RN_RD:  state_nxt = ST_RN_EV;
      ST_RN_EV:  state_nxt = (stat.digit_a || stat.digit_b) ? ST_RN_RD : ST_RN_CMP;
      ST_RN_CMP: state_nxt = stat.run_ne ? ST_FINISH : ST_DG_RD;
      ST_DG_RD:  state_nxt = stat.digits_done ? ST_CH_RD : ST_DG_EV;
      ST_DG_EV:  state_nxt = stat.char_ne ? ST_FINISH : ST_DG_RD;
      ST_FINISH: state_nxt = stat.out_free ? ST_IDLE : ST_FINISH;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.ptr_op    = PTR_HOLD;
    cmd.run_op    = RUN_HOLD;
    cmd.res_src   = RES_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == CMD_COMPARE) begin
            if (stat.absent_any) begin
              cmd.res_src = RES_ABSENT;
            end else begin
              cmd.ptr_op = PTR_ZERO;
            end
          end else begin
            cmd.item_take = 1'b1;
          end
        end
      end
      ST_ART_EV: begin
        cmd.art_shift = 1'b1;
        if (!stat.art_last) begin
          cmd.ptr_op = PTR_STEP;
          cmd.step_a = 1'b1;
          cmd.step_b = 1'b1;
        end
      end
      ST_ART_SET: begin
        cmd.ptr_op = PTR_ARTICLE;
      end
      ST_CH_EV: begin
        priority if (stat.end_a || stat.end_b) begin
          cmd.res_src = RES_END;
        end else if (stat.digit_a && stat.digit_b) begin
          cmd.res_src = RES_HOLD;
        end else if (stat.char_ne) begin
          cmd.res_src = RES_CHAR;
        end else begin
          cmd.ptr_op = PTR_STEP;
          cmd.step_a = 1'b1;
          cmd.step_b = 1'b1;
        end
      end
      ST_ZS_EV: begin
        cmd.ptr_op = PTR_STEP;
        cmd.step_a = stat.zero_a;
        cmd.step_b = stat.zero_b;
        if (!stat.zero_a && !stat.zero_b) begin
          cmd.run_op = RUN_LOAD;
        end
      end
      ST_RN_RD: begin
        cmd.sel_run = 1'b1;
      end
      ST_RN_EV: begin
        cmd.sel_run = 1'b1;
        cmd.run_op  = RUN_STEP;
        cmd.step_a  = stat.digit_a;
        cmd.step_b  = stat.digit_b;
      end
      ST_RN_CMP: begin
        if (stat.run_ne) begin
          cmd.res_src = RES_RUN;
        end
      end
      ST_DG_EV: begin
        if (stat.char_ne) begin
          cmd.res_src = RES_CHAR;
        end else begin
          cmd.ptr_op = PTR_STEP;
          cmd.step_a = 1'b1;
          cmd.step_b = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      ST_ART_RD, ST_CH_RD, ST_ZS_RD, ST_DG_RD: begin
        cmd.res_src = RES_HOLD;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/nsc_dp.sv]
// nsc_dp: string buffers, scan pointers, result and output registers
`timescale 1ns / 1ps
`default_nettype none

module nsc_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire nsc_pkg::in_item_t  in_item,
  input  wire nsc_pkg::ctrl_cmd_t cmd,
  output nsc_pkg::dp_stat_t       stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output nsc_pkg::out_item_t      out_item
);
  import nsc_pkg::*;

  logic [7:0]               mem_a [MAX_LEN];
  logic [7:0]               mem_b [MAX_LEN];
  logic [7:0]               rd_a_r;
  logic [7:0]               rd_b_r;
  logic [LEN_W-1:0]         len_a_r;
  logic [LEN_W-1:0]         len_b_r;
  logic                     absent_a_r;
  logic                     absent_b_r;
  logic                     trunc_r;
  logic [LEN_W-1:0]         i_r;
  logic [LEN_W-1:0]         j_r;
  logic [LEN_W-1:0]         ea_r;
  logic [LEN_W-1:0]         eb_r;
  logic [ART_W-1:0]         art_a_r;
  logic [ART_W-1:0]         art_b_r;
  logic signed [DIFF_W-1:0] res_r;
  logic signed [DIFF_W-1:0] res_nxt;
  logic                     out_valid_r;
  out_item_t                out_item_r;

  logic                     app_a;
  logic                     app_b;
  logic                     wr_a;
  logic                     wr_b;
  logic [LEN_W-1:0]         idx_a;
  logic [LEN_W-1:0]         idx_b;
  logic [7:0]               byte_a;
  logic [7:0]               byte_b;
  logic [7:0]               low_a;
  logic [7:0]               low_b;
  logic [LEN_W-1:0]         run_a;
  logic [LEN_W-1:0]         run_b;
  logic signed [LEN_W:0]    run_diff;
  logic signed [DIFF_W-1:0] res_run;
  logic signed [DIFF_W-1:0] res_char;
  logic                     out_free;

  // append decode
  assign app_a = cmd.item_take && in_item.command == CMD_APPEND_A && in_item.char_code != CH_NUL;
  assign app_b = cmd.item_take && in_item.command == CMD_APPEND_B && in_item.char_code != CH_NUL;
  assign wr_a  = app_a && (len_a_r < LEN_W'(MAX_LEN));
  assign wr_b  = app_b && (len_b_r < LEN_W'(MAX_LEN));

  // current scan positions, run end pointers while counting digit runs
  assign idx_a = cmd.sel_run ? ea_r : i_r;
  assign idx_b = cmd.sel_run ? eb_r : j_r;

  // buffer a: one write port for appends, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[len_a_r[ADDR_W-1:0]] <= in_item.char_code;
    end
    rd_a_r <= mem_a[idx_a[ADDR_W-1:0]];
  end

  // buffer b
  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[len_b_r[ADDR_W-1:0]] <= in_item.char_code;
    end
    rd_b_r <= mem_b[idx_b[ADDR_W-1:0]];
  end

  // lengths, null marks and truncation flag, cleared once a result is issued
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      len_a_r    <= '0;
      len_b_r    <= '0;
      absent_a_r <= 1'b0;
      absent_b_r <= 1'b0;
      trunc_r    <= 1'b0;
    end else begin
      if (wr_a) begin
        len_a_r <= len_a_r + LEN_W'(1);
      end
      if (wr_b) begin
        len_b_r <= len_b_r + LEN_W'(1);
      end
      if ((app_a && !wr_a) || (app_b && !wr_b)) begin
        trunc_r <= 1'b1;
      end
      if (cmd.item_take && in_item.command == CMD_NULL_A) begin
        absent_a_r <= 1'b1;
      end
      if (cmd.item_take && in_item.command == CMD_NULL_B) begin
        absent_b_r <= 1'b1;
      end
    end
  end

  // bytes past the end read as nul
  assign byte_a = (idx_a < len_a_r) ? rd_a_r : CH_NUL;
  assign byte_b = (idx_b < len_b_r) ? rd_b_r : CH_NUL;
  assign low_a  = to_lower(byte_a);
  assign low_b  = to_lower(byte_b);

  // scan pointers
  always_ff @(posedge clk) begin
    unique case (cmd.ptr_op)
      PTR_ZERO: begin
        i_r <= '0;
        j_r <= '0;
      end
      PTR_ARTICLE: begin
        i_r <= article_len(art_a_r);
        j_r <= article_len(art_b_r);
      end
      PTR_STEP: begin
        if (cmd.step_a) begin
          i_r <= i_r + LEN_W'(1);
        end
        if (cmd.step_b) begin
          j_r <= j_r + LEN_W'(1);
        end
      end
      default: begin
        i_r <= i_r;
        j_r <= j_r;
      end
    endcase
  end

  // digit run end pointers
  always_ff @(posedge clk) begin
    unique case (cmd.run_op)
      RUN_LOAD: begin
        ea_r <= i_r;
        eb_r <= j_r;
      end
      RUN_STEP: begin
        if (cmd.step_a) begin
          ea_r <= ea_r + LEN_W'(1);
        end
        if (cmd.step_b) begin
          eb_r <= eb_r + LEN_W'(1);
        end
      end
      default: begin
        ea_r <= ea_r;
        eb_r <= eb_r;
      end
    endcase
  end

  // leading bytes gathered for the article check
  always_ff @(posedge clk) begin
    if (cmd.art_shift) begin
      art_a_r <= {art_a_r[ART_W-9:0], byte_a};
      art_b_r <= {art_b_r[ART_W-9:0], byte_b};
    end
  end

  // run lengths and their saturated difference
  assign run_a    = ea_r - i_r;
  assign run_b    = eb_r - j_r;
  assign run_diff = $signed({1'b0, run_a}) - $signed({1'b0, run_b});

  always_comb begin
    priority if (run_diff > DIFF_LIMIT) begin
      res_run = DIFF_HI;
    end else if (run_diff < -DIFF_LIMIT) begin
      res_run = DIFF_LO;
    end else begin
      res_run = DIFF_W'(run_diff);
    end
  end

  // lower-cased byte difference; digits are unchanged by lower-casing
  assign res_char = $signed({{(DIFF_W-8){1'b0}}, low_a}) - $signed({{(DIFF_W-8){1'b0}}, low_b});

  // result select
  always_comb begin
    res_nxt = res_r;
    unique case (cmd.res_src)
      RES_ABSENT: begin
        priority if (absent_a_r && absent_b_r) begin
          res_nxt = DIFF_ZERO;
        end else if (absent_a_r) begin
          res_nxt = DIFF_NEG_ONE;
        end else begin
          res_nxt = DIFF_ONE;
        end
      end
      RES_END: begin
        priority if (byte_a != CH_NUL) begin
          res_nxt = DIFF_ONE;
        end else if (byte_b != CH_NUL) begin
          res_nxt = DIFF_NEG_ONE;
        end else begin
          res_nxt = DIFF_ZERO;
        end
      end
      RES_CHAR: res_nxt = res_char;
      RES_RUN:  res_nxt = res_run;
      default:  res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // output register, free when empty or being taken
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.difference <= res_r;
      out_item_r.overflowed <= trunc_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // status to the controller
  always_comb begin
    stat.absent_any  = absent_a_r || absent_b_r;
    stat.end_a       = byte_a == CH_NUL;
    stat.end_b       = byte_b == CH_NUL;
    stat.digit_a     = is_digit(byte_a);
    stat.digit_b     = is_digit(byte_b);
    stat.zero_a      = byte_a == CH_ZERO;
    stat.zero_b      = byte_b == CH_ZERO;
    stat.char_ne     = low_a != low_b;
    stat.art_last    = i_r == LEN_W'(ART_BYTES - 1);
    stat.run_ne      = run_a != run_b;
    stat.digits_done = i_r == ea_r;
    stat.out_free    = out_free;
  end

endmodule

`default_nettype wire

[sv/natural_string_compare.sv]
// natural_string_compare: top level of the natural order, case-insensitive string compare
//
//   channel  direction  ports                          payload
//   in_      input      in_valid, in_ready, in_item    command, char_code
//   out_     output     out_valid, out_ready, out_item difference, overflowed
//
// appends and null marks are taken in the idle state. a compare reads the leading
// bytes for the article check, walks the plain bytes up to the end check, skips
// leading zeros, counts and compares both digit runs, compares equal runs digit by
// digit and posts the result; a null string compare goes straight to posting. reads
// and evaluates are separate states, set by the single registered read port per buffer.
// reset is synchronous: lengths, null marks and the output register clear at once,
// buffer contents are not cleared.
// in_ready is high whenever the walk is idle, also while a result waits on out_ready;
// a finished compare waits in its last state until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module natural_string_compare (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire nsc_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output nsc_pkg::out_item_t     out_item
);
  import nsc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  nsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .command  (in_item.command),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // buffers and compare datapath
  nsc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[sv/nsc_checker.sv]
// nsc_checker: port-level assertions for the string compare, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module nsc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire nsc_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire nsc_pkg::out_item_t out_item
);
  import nsc_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // a compare item makes the block busy
  a_cmp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.command == CMD_COMPARE |=> !in_ready)
    else $error("ready stayed high after a compare item");

  // loads and null marks never stall the input
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.command != CMD_COMPARE |=> in_ready)
    else $error("ready dropped after a load item");

  // a new result only appears at the end of a compare walk
  a_out_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result item appeared while idle");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid after reset");

endmodule

bind natural_string_compare nsc_checker u_nsc_checker (.*);

`default_nettype wire
